@@ hdl/pnro_pkg.sv @@
// ----------------------------------------------------------------------------
// pnro_pkg
// Shared types and constants of the portal normal reduce and orient unit:
// field widths, sequencer states, datapath operation codes and the control
// and status bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pnro_pkg;

  // Width of every coordinate and result field.
  localparam int COORD_W = 16;
  // Corner differences carry one extra bit.
  localparam int DIFF_W  = COORD_W + 1;
  // Product of two differences.
  localparam int PROD_W  = 2 * DIFF_W;
  // Difference of two products, before the magnitude is taken.
  localparam int SUM_W   = PROD_W + 1;
  // Magnitude of a cross product component: below 2 * (2^COORD_W - 1)^2.
  localparam int MAG_W   = 2 * COORD_W + 1;
  // Counter for division steps and the common power of two of the GCD.
  localparam int CNT_W   = $clog2(MAG_W);
  // Last step of the six-product sequence, including the drain step.
  localparam int MUL_LAST = 6;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_GCD,
    ST_DIV,
    ST_STORE,
    ST_ORIENT,
    ST_DONE
  } st_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_GCD_SCALE,
    OP_GCD_NEXT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_NEXT,
    OP_ORIENT
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_DEGEN,
    RES_STORED,
    RES_REDUCED
  } res_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] sel;
    res_e       res;
  } dp_ctrl_t;

  typedef struct packed {
    logic all_zero;
    logic sy_zero;
    logic a_zero;
    logic b_zero;
    logic k_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/pnro_dpath.sv @@
// ----------------------------------------------------------------------------
// pnro_dpath
// Arithmetic datapath: corner differences, one shared signed multiplier,
// a binary GCD step unit and a restoring divider, all driven one operation
// per cycle by the sequencer in the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pnro_dpath (
  input  wire               clk_i,
  input  pnro_pkg::dp_ctrl_t ctrl_i,
  output pnro_pkg::dp_stat_t stat_o,
  input  pnro_pkg::coord_t  corner0_x_i,
  input  pnro_pkg::coord_t  corner0_y_i,
  input  pnro_pkg::coord_t  corner0_z_i,
  input  pnro_pkg::coord_t  corner1_x_i,
  input  pnro_pkg::coord_t  corner1_y_i,
  input  pnro_pkg::coord_t  corner1_z_i,
  input  pnro_pkg::coord_t  corner2_x_i,
  input  pnro_pkg::coord_t  corner2_y_i,
  input  pnro_pkg::coord_t  corner2_z_i,
  input  pnro_pkg::coord_t  stored_normal_x_i,
  input  pnro_pkg::coord_t  stored_normal_y_i,
  input  pnro_pkg::coord_t  stored_normal_z_i,
  output pnro_pkg::coord_t  res_x_o,
  output pnro_pkg::coord_t  res_y_o,
  output pnro_pkg::coord_t  res_z_o
);
  import pnro_pkg::*;

  logic signed [DIFF_W-1:0] u_q [3];
  logic signed [DIFF_W-1:0] v_q [3];
  coord_t                   snx_q, sny_q, snz_q;
  logic signed [PROD_W-1:0] p_q, acc_q;
  logic        [MAG_W-1:0]  mag_q [3];
  logic                     neg_q [3];
  logic        [MAG_W-1:0]  a_q, b_q;
  logic        [CNT_W-1:0]  k_q;
  logic        [MAG_W-1:0]  rem_q, dvd_q;

  logic        [1:0]        u_idx, v_idx, n_idx;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  cross_sum;
  logic                     cross_neg;
  logic signed [SUM_W-1:0]  cross_abs;
  logic        [MAG_W:0]    ab_diff, ba_diff;
  logic                     a_ge_b;
  logic        [MAG_W:0]    shifted;
  logic        [MAG_W+1:0]  trial;
  logic                     borrow;
  logic        [COORD_W:0]  sy_ext, sy_abs;
  logic                     same;
  coord_t                   wrap [3];

  // Operand selection for the six products of the cross product.
  always_comb begin
    case (ctrl_i.sel)
      3'd0:    begin u_idx = 2'd1; v_idx = 2'd2; end
      3'd1:    begin u_idx = 2'd2; v_idx = 2'd1; end
      3'd2:    begin u_idx = 2'd2; v_idx = 2'd0; end
      3'd3:    begin u_idx = 2'd0; v_idx = 2'd2; end
      3'd4:    begin u_idx = 2'd0; v_idx = 2'd1; end
      3'd5:    begin u_idx = 2'd1; v_idx = 2'd0; end
      default: begin u_idx = 2'd0; v_idx = 2'd0; end
    endcase
  end

  assign n_idx     = ctrl_i.sel[2:1] - 2'd1;
  assign prod      = u_q[u_idx] * v_q[v_idx];
  assign cross_sum = {acc_q[PROD_W-1], acc_q} - {p_q[PROD_W-1], p_q};
  assign cross_neg = cross_sum[SUM_W-1];
  assign cross_abs = cross_neg ? -cross_sum : cross_sum;

  assign ab_diff = {1'b0, a_q} - {1'b0, b_q};
  assign ba_diff = -ab_diff;
  assign a_ge_b  = !ab_diff[MAG_W];

  assign shifted = {rem_q, dvd_q[MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, b_q};
  assign borrow  = trial[MAG_W+1];

  assign sy_ext = {sny_q[COORD_W-1], sny_q};
  assign sy_abs = sny_q[COORD_W-1] ? -sy_ext : sy_ext;
  assign same   = (mag_q[1] == {{(MAG_W-COORD_W-1){1'b0}}, sy_abs})
                  && (neg_q[1] == sny_q[COORD_W-1]);

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        u_q[0] <= DIFF_W'(corner1_x_i) - DIFF_W'(corner0_x_i);
        u_q[1] <= DIFF_W'(corner1_y_i) - DIFF_W'(corner0_y_i);
        u_q[2] <= DIFF_W'(corner1_z_i) - DIFF_W'(corner0_z_i);
        v_q[0] <= DIFF_W'(corner2_x_i) - DIFF_W'(corner0_x_i);
        v_q[1] <= DIFF_W'(corner2_y_i) - DIFF_W'(corner0_y_i);
        v_q[2] <= DIFF_W'(corner2_z_i) - DIFF_W'(corner0_z_i);
        snx_q  <= stored_normal_x_i;
        sny_q  <= stored_normal_y_i;
        snz_q  <= stored_normal_z_i;
      end
      OP_MUL: begin
        // Odd steps move the first product aside, even steps form a component.
        if (ctrl_i.sel != 3'd0) begin
          if (ctrl_i.sel[0]) begin
            acc_q <= p_q;
          end else begin
            mag_q[n_idx] <= cross_abs[MAG_W-1:0];
            neg_q[n_idx] <= cross_neg;
          end
        end
        if (ctrl_i.sel < 3'(MUL_LAST)) begin
          p_q <= prod;
        end
      end
      OP_GCD_INIT: begin
        a_q <= mag_q[0];
        b_q <= mag_q[1];
        k_q <= '0;
      end
      OP_GCD_NEXT: begin
        a_q <= b_q;
        b_q <= mag_q[2];
        k_q <= '0;
      end
      OP_GCD_STEP: begin
        if (b_q == '0) begin
          a_q <= '0;
          b_q <= a_q;
        end else if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_ge_b) begin
          a_q <= {1'b0, ab_diff[MAG_W-1:1]};
        end else begin
          b_q <= {1'b0, ba_diff[MAG_W-1:1]};
        end
      end
      OP_GCD_SCALE: begin
        b_q <= b_q << 1;
        k_q <= k_q - 1'b1;
      end
      OP_DIV_INIT: begin
        rem_q <= '0;
        dvd_q <= mag_q[0];
      end
      OP_DIV_STEP: begin
        rem_q <= borrow ? shifted[MAG_W-1:0] : trial[MAG_W-1:0];
        dvd_q <= {dvd_q[MAG_W-2:0], !borrow};
      end
      OP_DIV_NEXT: begin
        mag_q[ctrl_i.sel[1:0]] <= dvd_q;
        rem_q <= '0;
        dvd_q <= (ctrl_i.sel[1:0] == 2'd0) ? mag_q[1] : mag_q[2];
      end
      OP_ORIENT: begin
        if (!same) begin
          for (int i = 0; i < 3; i++) begin
            if (mag_q[i] != '0) neg_q[i] <= !neg_q[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wrap[i] = neg_q[i] ? -mag_q[i][COORD_W-1:0] : mag_q[i][COORD_W-1:0];
    end
  end

  always_comb begin
    unique case (ctrl_i.res)
      RES_DEGEN: begin
        res_x_o = '0;
        res_y_o = COORD_W'(1);
        res_z_o = '0;
      end
      RES_STORED: begin
        res_x_o = snx_q;
        res_y_o = sny_q;
        res_z_o = snz_q;
      end
      default: begin
        res_x_o = wrap[0];
        res_y_o = wrap[1];
        res_z_o = wrap[2];
      end
    endcase
  end

  assign stat_o.all_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign stat_o.sy_zero  = (sny_q == '0);
  assign stat_o.a_zero   = (a_q == '0);
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.k_zero   = (k_q == '0);

endmodule

`default_nettype wire

@@ hdl/portal_normal_reduce_orient_unit.sv @@
// ----------------------------------------------------------------------------
// portal_normal_reduce_orient_unit
// Computes the integer normal of a polygon from three corners, divides it by
// the GCD of its component magnitudes and orients it by the stored normal y.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   -------  ---------  -------------------------  -------------------------
//   in       slave      in_valid_i / in_stall_o    corner0..2 x/y/z, stored
//                                                  normal x/y/z
//   out      master     out_valid_o / out_stall_i  normal x/y/z
//
// An item runs through the load, the six products, the zero checks, two binary
// GCD passes, three divisions and the orientation step, paced by the shared GCD
// step unit and the one-bit-a-cycle divider. A zero cross product or stored y
// skips the GCD, the divisions and the orientation. Reset clears the sequencer
// and output valid, not the datapath. The input stalls while an item is in
// work; a finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module portal_normal_reduce_orient_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  pnro_pkg::coord_t corner0_x_i,
  input  pnro_pkg::coord_t corner0_y_i,
  input  pnro_pkg::coord_t corner0_z_i,
  input  pnro_pkg::coord_t corner1_x_i,
  input  pnro_pkg::coord_t corner1_y_i,
  input  pnro_pkg::coord_t corner1_z_i,
  input  pnro_pkg::coord_t corner2_x_i,
  input  pnro_pkg::coord_t corner2_y_i,
  input  pnro_pkg::coord_t corner2_z_i,
  input  pnro_pkg::coord_t stored_normal_x_i,
  input  pnro_pkg::coord_t stored_normal_y_i,
  input  pnro_pkg::coord_t stored_normal_z_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output pnro_pkg::coord_t normal_x_o,
  output pnro_pkg::coord_t normal_y_o,
  output pnro_pkg::coord_t normal_z_o
);
  import pnro_pkg::*;

  st_e              state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             pass_q, pass_d;
  res_e             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  coord_t           normal_x_q, normal_y_q, normal_z_q;

  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  coord_t           res_x, res_y, res_z;
  logic             in_xfer;
  logic             out_load;

  // The input is open only between items.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // A finished result enters the output register when it is empty or its
  // current contents leave in this cycle.
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  pnro_dpath u_dpath (
    .clk_i             (clk_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .corner0_x_i       (corner0_x_i),
    .corner0_y_i       (corner0_y_i),
    .corner0_z_i       (corner0_z_i),
    .corner1_x_i       (corner1_x_i),
    .corner1_y_i       (corner1_y_i),
    .corner1_z_i       (corner1_z_i),
    .corner2_x_i       (corner2_x_i),
    .corner2_y_i       (corner2_y_i),
    .corner2_z_i       (corner2_z_i),
    .stored_normal_x_i (stored_normal_x_i),
    .stored_normal_y_i (stored_normal_y_i),
    .stored_normal_z_i (stored_normal_z_i),
    .res_x_o           (res_x),
    .res_y_o           (res_y),
    .res_z_o           (res_z)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(MUL_LAST)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // Degenerate corners and a zero stored y need no reduction.
        if (stat.all_zero || stat.sy_zero) state_d = ST_DONE;
        else state_d = ST_GCD;
      end
      ST_GCD: begin
        if (stat.a_zero && stat.k_zero && pass_q) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(MAG_W - 1)) state_d = ST_STORE;
      end
      ST_STORE: begin
        if (comp_q == 2'd2) state_d = ST_ORIENT;
        else state_d = ST_DIV;
      end
      ST_ORIENT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands and sequencer counters.
  always_comb begin
    ctrl.op  = OP_NONE;
    ctrl.sel = {1'b0, comp_q};
    ctrl.res = res_q;
    cnt_d    = cnt_q;
    comp_d   = comp_q;
    pass_d   = pass_q;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.op = OP_LOAD;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        ctrl.op  = OP_MUL;
        ctrl.sel = cnt_q[2:0];
        cnt_d    = cnt_q + 1'b1;
      end
      ST_CHECK: begin
        if (stat.all_zero) begin
          res_d = RES_DEGEN;
        end else if (stat.sy_zero) begin
          res_d = RES_STORED;
        end else begin
          ctrl.op = OP_GCD_INIT;
          pass_d  = 1'b0;
          res_d   = RES_REDUCED;
        end
      end
      ST_GCD: begin
        if (!stat.a_zero) begin
          ctrl.op = OP_GCD_STEP;
        end else if (!stat.k_zero) begin
          // Put back the power of two that both operands shared.
          ctrl.op = OP_GCD_SCALE;
        end else if (!pass_q) begin
          // Fold in the third component.
          ctrl.op = OP_GCD_NEXT;
          pass_d  = 1'b1;
        end else begin
          ctrl.op  = OP_DIV_INIT;
          ctrl.sel = 3'd0;
          comp_d   = 2'd0;
          cnt_d    = '0;
        end
      end
      ST_DIV: begin
        ctrl.op = OP_DIV_STEP;
        cnt_d   = cnt_q + 1'b1;
      end
      ST_STORE: begin
        // Keep the quotient and start on the next component.
        ctrl.op = OP_DIV_NEXT;
        cnt_d   = '0;
        if (comp_q != 2'd2) comp_d = comp_q + 2'd1;
      end
      ST_ORIENT: begin
        ctrl.op = OP_ORIENT;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      pass_q      <= 1'b0;
      res_q       <= RES_DEGEN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      pass_q      <= pass_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      normal_x_q <= res_x;
      normal_y_q <= res_y;
      normal_z_q <= res_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = normal_x_q;
  assign normal_y_o  = normal_y_q;
  assign normal_z_o  = normal_z_q;

  // The divisor is the finished GCD, which is never zero for a nonzero vector.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !stat.b_zero)
    else $error("divider entered with a zero GCD");

  // The division counter never runs past the magnitude width.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CNT_W'(MAG_W)))
    else $error("division step count out of range");

  // A finished result with an empty output register is shown next cycle and
  // the block is open for the next item.
  a_done_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not handed to the output register");

  // An accepted item starts the product sequence with the input side closed.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer) |=> (state_q == ST_MUL && in_stall_o))
    else $error("accepted item did not start the product sequence");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the portal normal reduce and orient unit. A queue
// of polygons (a directed opening set, then a weighted random mix) feeds a
// bursty driver. Each accepted transfer is predicted with exact 64-bit
// arithmetic, and the results are compared in order against a stalling
// receiver.
// ----------------------------------------------------------------------------

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import pnro_pkg::*;

  // Directed polygons come first; this many random ones follow them.
  localparam int RANDOM_POLYS = 434;
  // Wait longer than a full item takes after the last result, so that a stray
  // extra result is still caught.
  localparam int DRAIN_CYCLES = 400;
  // Keep the log short if the design is badly broken.
  localparam int REPORT_LIMIT = 40;
  // A zero cross product always yields the upward unit normal.
  localparam coord_t DEGEN_Y  = 1;

  // One input item: three corners and the stored normal.
  typedef struct {
    coord_t corner0_x, corner0_y, corner0_z;
    coord_t corner1_x, corner1_y, corner1_z;
    coord_t corner2_x, corner2_y, corner2_z;
    coord_t stored_normal_x, stored_normal_y, stored_normal_z;
  } poly_t;

  // One result item as it shows up on the output ports.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } normal_t;

  // Exact, unwrapped normal. The components stay below 2^34 in magnitude,
  // so a longint holds every intermediate value without overflow.
  typedef struct {
    longint x, y, z;
  } vec_t;

  // Shapes of random polygons.
  typedef enum int {
    MIX_RANDOM,
    MIX_SMALL,
    MIX_FLAT,
    MIX_DEGEN,
    MIX_EXTREME,
    MIX_SCALED
  } mix_e;

  // Receiver back-pressure patterns.
  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_e;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;

  logic    in_valid   = 1'b0;
  logic    in_stall;
  poly_t   drive_item = '{default: '0};
  logic    out_valid;
  logic    out_stall  = 1'b0;
  normal_t out_normal;

  poly_t   pending_polys[$];
  normal_t expected_normals[$];
  int      total_polys    = 0;
  int      accepted_polys = 0;
  int      mismatches     = 0;

  int       gap_left   = 0;
  int       burst_left = 0;
  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_left    = 0;

  portal_normal_reduce_orient_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .corner0_x_i       (drive_item.corner0_x),
    .corner0_y_i       (drive_item.corner0_y),
    .corner0_z_i       (drive_item.corner0_z),
    .corner1_x_i       (drive_item.corner1_x),
    .corner1_y_i       (drive_item.corner1_y),
    .corner1_z_i       (drive_item.corner1_z),
    .corner2_x_i       (drive_item.corner2_x),
    .corner2_y_i       (drive_item.corner2_y),
    .corner2_z_i       (drive_item.corner2_z),
    .stored_normal_x_i (drive_item.stored_normal_x),
    .stored_normal_y_i (drive_item.stored_normal_y),
    .stored_normal_z_i (drive_item.stored_normal_z),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .normal_x_o        (out_normal.x),
    .normal_y_o        (out_normal.y),
    .normal_z_o        (out_normal.z)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Greatest common divisor of two magnitudes. A zero operand simply drops
  // out, which is how zero components are skipped.
  function automatic longint magnitude_gcd(longint a, longint b);
    longint r;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Exact cross product (c1 - c0) x (c2 - c0), divided by the GCD of its
  // components. A zero vector comes back unchanged.
  function automatic vec_t cross_reduced(poly_t p);
    longint ux, uy, uz, vx, vy, vz, g;
    vec_t   n;
    ux = longint'(p.corner1_x) - longint'(p.corner0_x);
    uy = longint'(p.corner1_y) - longint'(p.corner0_y);
    uz = longint'(p.corner1_z) - longint'(p.corner0_z);
    vx = longint'(p.corner2_x) - longint'(p.corner0_x);
    vy = longint'(p.corner2_y) - longint'(p.corner0_y);
    vz = longint'(p.corner2_z) - longint'(p.corner0_z);
    n.x = uy * vz - uz * vy;
    n.y = uz * vx - ux * vz;
    n.z = ux * vy - uy * vx;
    g = magnitude_gcd(magnitude_gcd(n.x, n.y), n.z);
    if (g != 0) begin
      n.x = n.x / g;
      n.y = n.y / g;
      n.z = n.z / g;
    end
    return n;
  endfunction

  // Expected output for one polygon.
  function automatic normal_t predict_normal(poly_t p);
    vec_t    n;
    normal_t r;
    n = cross_reduced(p);
    if (n.x == 0 && n.y == 0 && n.z == 0) begin
      // Degenerate corners: fixed upward normal, stored normal ignored.
      r = '{x: '0, y: DEGEN_Y, z: '0};
    end else if (p.stored_normal_y == 0) begin
      // Nothing to orient against: the stored normal passes through as is.
      r = '{x: p.stored_normal_x, y: p.stored_normal_y, z: p.stored_normal_z};
    end else begin
      // The comparison uses the exact reduced y, not its 16-bit wrap.
      if (n.y != longint'(p.stored_normal_y)) begin
        n.x = -n.x;
        n.y = -n.y;
        n.z = -n.z;
      end
      r = '{x: coord_t'(n.x), y: coord_t'(n.y), z: coord_t'(n.z)};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  function automatic poly_t make_poly(input int ax, ay, az, bx, by, bz,
                                      cx, cy, cz, sx, sy, sz);
    poly_t p;
    p.corner0_x = coord_t'(ax);
    p.corner0_y = coord_t'(ay);
    p.corner0_z = coord_t'(az);
    p.corner1_x = coord_t'(bx);
    p.corner1_y = coord_t'(by);
    p.corner1_z = coord_t'(bz);
    p.corner2_x = coord_t'(cx);
    p.corner2_y = coord_t'(cy);
    p.corner2_z = coord_t'(cz);
    p.stored_normal_x = coord_t'(sx);
    p.stored_normal_y = coord_t'(sy);
    p.stored_normal_z = coord_t'(sz);
    return p;
  endfunction

  // A random polygon. Fully random corners exercise every bit and produce
  // wide, coprime normals; the other shapes reach the degenerate case, large
  // common divisors, axis-aligned portals and the orientation compare.
  function automatic poly_t random_poly();
    poly_t  p;
    vec_t   n;
    coord_t c[9];
    int     pick, k, axis, step, scale;
    mix_e   kind;
    pick = $urandom_range(0, 9);
    if (pick < 4) kind = MIX_RANDOM;
    else if (pick < 6) kind = MIX_SMALL;
    else if (pick == 6) kind = MIX_FLAT;
    else if (pick == 7) kind = MIX_DEGEN;
    else if (pick == 8) kind = MIX_EXTREME;
    else kind = MIX_SCALED;

    for (k = 0; k < 9; k++) c[k] = coord_t'($urandom);
    case (kind)
      MIX_SMALL: begin
        for (k = 0; k < 9; k++) c[k] = coord_t'(int'($urandom_range(0, 16)) - 8);
      end
      MIX_FLAT: begin
        // All three corners share one coordinate, like a wall or floor portal.
        axis = $urandom_range(0, 2);
        c[3 + axis] = c[axis];
        c[6 + axis] = c[axis];
      end
      MIX_DEGEN: begin
        case ($urandom_range(0, 2))
          0: for (k = 0; k < 3; k++) c[3 + k] = c[k];
          1: for (k = 0; k < 3; k++) c[6 + k] = c[3 + k];
          default: begin
            // Three points on one line.
            for (k = 0; k < 3; k++) begin
              c[k]     = coord_t'(int'($urandom_range(0, 40000)) - 20000);
              step     = int'($urandom_range(0, 200)) - 100;
              c[3 + k] = coord_t'(int'(c[k]) + step);
              c[6 + k] = coord_t'(int'(c[k]) + 3 * step);
            end
          end
        endcase
      end
      MIX_EXTREME: begin
        for (k = 0; k < 9; k++) begin
          case ($urandom_range(0, 4))
            0: c[k] = coord_t'(-32768);
            1: c[k] = coord_t'(-1);
            2: c[k] = '0;
            3: c[k] = coord_t'(1);
            default: c[k] = coord_t'(32767);
          endcase
        end
      end
      MIX_SCALED: begin
        // Common factor in every difference gives a large GCD.
        scale = $urandom_range(1, 300);
        for (k = 0; k < 9; k++)
          c[k] = coord_t'(scale * (int'($urandom_range(0, 200)) - 100));
      end
      default: ;
    endcase

    p = make_poly(int'(c[0]), int'(c[1]), int'(c[2]), int'(c[3]), int'(c[4]),
                  int'(c[5]), int'(c[6]), int'(c[7]), int'(c[8]),
                  int'($urandom), int'($urandom), int'($urandom));

    // Pick the stored y so that zero, the matching sign and the opposite
    // sign all turn up often, not just by luck.
    n = cross_reduced(p);
    case ($urandom_range(0, 9))
      0, 1: p.stored_normal_y = '0;
      2, 3, 4: if (n.y >= -32768 && n.y <= 32767) p.stored_normal_y = coord_t'(n.y);
      5, 6: if (n.y >= -32767 && n.y <= 32768) p.stored_normal_y = coord_t'(-n.y);
      default: ;
    endcase
    return p;
  endfunction

  task automatic compare_component(string name, coord_t want, coord_t got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // The input side sends in bursts of one to six polygons. After each burst
  // it may pause, with the pause drawn from a short range three times in four
  // and from a long one otherwise, so that the gaps land on every phase of the
  // unit's sequence. A polygon stays on the bus, unchanged, until its transfer
  // completes. The expected normal is computed at the edge of the transfer.
  always @(posedge clk_i or negedge rst_ni) begin : feeder
    poly_t nxt;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      drive_item <= '{default: '0};
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_normals.push_back(predict_normal(drive_item));
        accepted_polys++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_polys.size() != 0) begin
          nxt = pending_polys.pop_front();
          drive_item <= nxt;
          in_valid   <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 6);
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                       : $urandom_range(0, 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure
  // --------------------------------------------------------------------------
  // The stall line runs through stretches of different character: fully
  // open, toggling at random, stalling now and then, or blocked outright.
  // A blocked stretch holds a finished result in the output register while
  // the unit already works on the next polygon.
  always @(posedge clk_i or negedge rst_ni) begin : rx_pattern
    rx_mode_e mode_now;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_mode   <= RX_OPEN;
      rx_left   <= 0;
    end else begin
      if (rx_left == 0) begin
        mode_now = rx_mode_e'($urandom_range(0, 3));
        rx_mode  <= mode_now;
        rx_left  <= (mode_now == RX_BLOCKED) ? $urandom_range(1, 150)
                                             : $urandom_range(1, 400);
      end else begin
        mode_now = rx_mode;
        rx_left  <= rx_left - 1;
      end
      case (mode_now)
        RX_CHOPPY:  out_stall <= 1'($urandom_range(0, 1));
        RX_SPARSE:  out_stall <= ($urandom_range(0, 7) == 0);
        RX_BLOCKED: out_stall <= 1'b1;
        default:    out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  // Every output transfer is matched, in order, against the oldest
  // expected normal.
  always @(posedge clk_i) begin : result_check
    normal_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: normal (%0d, %0d, %0d) expected none", $realtime,
                   out_normal.x, out_normal.y, out_normal.z);
        mismatches++;
      end else begin
        want = expected_normals.pop_front();
        compare_component("normal_x", want.x, out_normal.x);
        compare_component("normal_y", want.y, out_normal.y);
        compare_component("normal_z", want.z, out_normal.z);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    // Degenerate corners: all zero, all at the positive extreme with a
    // negative-extreme stored normal, and three collinear points.
    pending_polys.push_back(make_poly(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_polys.push_back(make_poly(32767, 32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, -32768, -32768, -32768));
    pending_polys.push_back(make_poly(1, 2, 3, 3, 6, 9, 5, 10, 15, 7, -9, 11));
    // Normal (0, -1, 0): stored y zero passes the stored normal through,
    // then a matching y, an opposite y and a negative extreme y.
    pending_polys.push_back(make_poly(0, 0, 0, 1, 0, 0, 0, 0, 1, 123, 0, -77));
    pending_polys.push_back(make_poly(0, 0, 0, 1, 0, 0, 0, 0, 1, 5, -1, 6));
    pending_polys.push_back(make_poly(0, 0, 0, 1, 0, 0, 0, 0, 1, 5, 1, 6));
    pending_polys.push_back(make_poly(0, 0, 0, 1, 0, 0, 0, 0, 1, -8, -32768, 9));
    // Full-range differences along the axes and the diagonals.
    pending_polys.push_back(make_poly(-32768, -32768, -32768, 32767, -32768, -32768,
                                      -32768, 32767, -32768, 0, 32767, 0));
    pending_polys.push_back(make_poly(-32768, -32768, 32767, 32767, -32768, -32768,
                                      -32768, 32767, -32768, 1, 1, 1));
    pending_polys.push_back(make_poly(-32768, -32768, -32768, 32767, 32766, -32768,
                                      -32768, 32767, 32767, 1, -1, 1));
    pending_polys.push_back(make_poly(32767, 32767, 32767, -32768, 32767, -32768,
                                      -32768, -32768, 32767, -1, 32767, -1));
    // Reduced normal (-163835, 32767, 8): x does not fit in 16 bits.
    pending_polys.push_back(make_poly(0, 0, 0, 1, 5, 0, 0, 8, -32767, 3, 32767, -3));
    pending_polys.push_back(make_poly(0, 0, 0, 1, 5, 0, 0, 8, -32767, 3, -32767, -3));
    pending_polys.push_back(make_poly(0, 0, 0, 1, 5, 0, 0, 8, -32767, -32768, 0, 32767));
    // Reduced normal (-2, 65541, -21847): the wrapped y equals the stored y,
    // but the exact y does not, so the vector must still be flipped.
    pending_polys.push_back(make_poly(0, 0, 0, 0, 1, 3, 21847, 1, 1, 9, 5, -9));
    pending_polys.push_back(make_poly(0, 0, 0, 0, 1, 3, 21847, 1, 1, 9, -5, -9));

    for (k = 0; k < RANDOM_POLYS; k++) pending_polys.push_back(random_poly());
    total_polys = pending_polys.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let every polygon go across, every normal come back, then watch the
    // outputs for a while longer.
    while (accepted_polys != total_polys) @(posedge clk_i);
    while (expected_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pnro_pkg.sv
hdl/pnro_dpath.sv
hdl/portal_normal_reduce_orient_unit.sv
bench/tb_top.sv
